/* sv/dsd_pkg.sv */
// ----------------------------------------------------------------------------
// dsd_pkg
// Shared types, character codes and calendar helpers for the date string
// difference unit.
// ----------------------------------------------------------------------------
package dsd_pkg;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// field widths
	localparam int DAY_W   = 7;
	localparam int MONTH_W = 7;
	localparam int YEAR_W  = 14;
	localparam int LEN_W   = 3;
	localparam int DAYS_W  = 6;
	localparam int MONS_W  = 4;

	// segment codes
	localparam logic [1:0] SEG_DAY   = 2'd0;
	localparam logic [1:0] SEG_MONTH = 2'd1;
	localparam logic [1:0] SEG_YEAR  = 2'd2;
	localparam logic [1:0] SEG_SKIP  = 2'd3;

	// field length limits
	localparam logic [LEN_W-1:0] LEN_MAX      = 3'd7;
	localparam logic [LEN_W-1:0] CAP_SHORT    = 3'd2;
	localparam logic [LEN_W-1:0] CAP_YEAR     = 3'd4;

	// two-digit years are taken in this century
	localparam logic [YEAR_W-1:0] YEAR_SHORT_MAX = 14'd99;
	localparam logic [YEAR_W-1:0] YEAR_OFFSET    = 14'd2000;

	// divisibility by 25: y * inverse(25) mod 2^14 <= (2^14 - 1) / 25
	localparam logic [YEAR_W-1:0] INV25     = 14'd7209;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 14'd655;

	localparam logic [MONS_W-1:0] MONTHS_PER_YEAR = 4'd12;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_START_BAD = 2'd1,
		STAT_END_BAD   = 2'd2,
		STAT_ORDER     = 2'd3
	} status_t;

	// one collected date string, handed from parser to calculator
	typedef struct packed {
		logic                second;
		logic [LEN_W-1:0]    len_day;
		logic [LEN_W-1:0]    len_month;
		logic [LEN_W-1:0]    len_year;
		logic [DAY_W-1:0]    day;
		logic [MONTH_W-1:0]  month;
		logic [YEAR_W-1:0]   year;
	} date_rec_t;

	// days in a month; month zero and unknown codes give 31
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

/* sv/date_string_difference_unit.sv */
// ----------------------------------------------------------------------------
// date_string_difference_unit
// Difference in years, months and days between two day/month/year strings.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one ASCII character per transaction; s_tlast
//   marks the last character of a date string. The first string is the
//   start date, the second the end date, and so on in pairs.
//   After each end string one transaction leaves on the master channel:
//   m_tuser holds the status (success, start invalid, end invalid, start
//   after end), m_tdata the years, months and days (zero unless success).
// Throughput: one character per cycle, back to back, unless a held result stalls the input.
// Path: m_tvalid rises once the end character has passed the input
//   register, the parser record register and the result register.
// Stall: the result register holds while m_tready is low; the next start
//   record still passes and the following end record waits at the parser
//   output. s_tready then drops once the next last character reaches the
//   input register, until the waiting result is taken.
// Reset: arst_n clears all handshake and parse state; the next string is
//   taken as a start date.
// ----------------------------------------------------------------------------
module date_string_difference_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] character
	input  logic        s_tlast,   // end_of_date
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [13:0] years, [17:14] months, [23:18] days
	output logic [1:0]  m_tuser    // [1:0] status
);
	import dsd_pkg::*;

	logic      rec_valid;
	logic      rec_ready;
	date_rec_t rec;

	// character parser
	dsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.rec_ready (rec_ready),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	// check and difference
	dsd_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_valid (rec_valid),
		.rec       (rec),
		.rec_ready (rec_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// input backpressure only comes from a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");

	// failed results carry no difference
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != STAT_OK)) |-> (m_tdata == 24'd0))
		else $error("nonzero payload on failed result");

	// remaining months stay below a year
	a_months_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_OK)) |-> (m_tdata[17:14] <= 4'd11))
		else $error("months out of range");

	// borrow never takes days below minus two
	a_days_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == STAT_OK)) |-> ($signed(m_tdata[23:18]) >= -6'sd2))
		else $error("days out of range");

endmodule

/* sv/dsd_parser.sv */
// ----------------------------------------------------------------------------
// dsd_parser
// Input register and character parser. Splits each date string into day,
// month and year fields and hands the finished record to the calculator.
// ----------------------------------------------------------------------------
module dsd_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] character
	input  logic               s_tlast,   // end_of_date
	input  logic               rec_ready,
	output logic               rec_valid,
	output dsd_pkg::date_rec_t rec
);
	import dsd_pkg::*;

	logic             valid_s1;
	logic [7:0]       ch_s1;
	logic             last_s1;
	logic             consume;

	logic             second_q;
	logic [1:0]       seg_q;
	logic [LEN_W-1:0] len_q [0:2];
	logic             ended_q;
	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;

	logic [1:0]       seg_n;
	logic [LEN_W-1:0] len_n [0:2];
	logic             ended_n;
	logic [DAY_W-1:0]   day_n;
	logic [MONTH_W-1:0] month_n;
	logic [YEAR_W-1:0]  year_n;

	logic [LEN_W-1:0] len_cur;
	logic [LEN_W-1:0] cap;
	logic [3:0]       digit;
	logic             is_digit;

	// a last character waits in s1 until the record slot is free
	assign consume  = valid_s1 && (!last_s1 || rec_ready);
	assign s_tready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// field update for the character in s1
	always_comb begin
		seg_n   = seg_q;
		len_n   = len_q;
		ended_n = ended_q;
		day_n   = day_q;
		month_n = month_q;
		year_n  = year_q;
		len_cur  = len_q[seg_q];
		cap      = (seg_q == SEG_YEAR) ? CAP_YEAR : CAP_SHORT;
		digit    = ch_s1[3:0];
		is_digit = ch_s1 inside {[CH_0:CH_9]};
		if (seg_q != SEG_SKIP) begin
			if (ch_s1 == CH_NUL) begin
				seg_n = SEG_SKIP;
			end else if (ch_s1 == CH_SLASH) begin
				seg_n   = 2'(seg_q + 2'd1);
				ended_n = 1'b0;
			end else begin
				if (is_digit) begin
					if (!ended_q && (len_cur < cap)) begin
						case (seg_q)
							SEG_DAY:   day_n = 7'({day_q, 3'b000} + {2'b00, day_q, 1'b0}
								+ {6'd0, digit});
							SEG_MONTH: month_n = 7'({month_q, 3'b000}
								+ {2'b00, month_q, 1'b0} + {6'd0, digit});
							default:   year_n = 14'({year_q, 3'b000}
								+ {2'b00, year_q, 1'b0} + {13'd0, digit});
						endcase
					end
				end else begin
					ended_n = 1'b1;
				end
				if (len_cur < LEN_MAX) begin
					len_n[seg_q] = 3'(len_cur + 3'd1);
				end
			end
		end
	end

	// parse state; cleared after each string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
			seg_q    <= SEG_DAY;
			len_q    <= '{default: '0};
			ended_q  <= 1'b0;
			day_q    <= '0;
			month_q  <= '0;
			year_q   <= '0;
		end else if (consume) begin
			if (last_s1) begin
				second_q <= !second_q;
				seg_q    <= SEG_DAY;
				len_q    <= '{default: '0};
				ended_q  <= 1'b0;
				day_q    <= '0;
				month_q  <= '0;
				year_q   <= '0;
			end else begin
				seg_q    <= seg_n;
				len_q    <= len_n;
				ended_q  <= ended_n;
				day_q    <= day_n;
				month_q  <= month_n;
				year_q   <= year_n;
			end
		end
	end

	// record register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid <= 1'b0;
		end else if (rec_ready) begin
			rec_valid <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			rec.second    <= second_q;
			rec.len_day   <= len_n[0];
			rec.len_month <= len_n[1];
			rec.len_year  <= len_n[2];
			rec.day       <= day_n;
			rec.month     <= month_n;
			rec.year      <= year_n;
		end
	end

endmodule

/* sv/dsd_calc.sv */
// ----------------------------------------------------------------------------
// dsd_calc
// Date check, start date store and year/month/day difference with the
// result register.
// ----------------------------------------------------------------------------
module dsd_calc (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rec_valid,
	input  dsd_pkg::date_rec_t rec,
	output logic               rec_ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [23:0]        m_tdata,   // [13:0] years, [17:14] months, [23:18] days
	output logic [1:0]         m_tuser    // [1:0] status
);
	import dsd_pkg::*;

	logic               take;
	logic [YEAR_W-1:0]  y_adj;
	logic [YEAR_W-1:0]  y_inv;
	logic               leap;
	logic [3:0]         mon;
	logic [4:0]         mlen;
	logic               len_ok;
	logic               ok;

	logic               start_valid_q;
	logic [DAY_W-1:0]   start_day_q;
	logic [3:0]         start_month_q;
	logic [YEAR_W-1:0]  start_year_q;

	logic               later;
	logic               borrow;
	logic [3:0]         m1b;
	logic [7:0]         d1b;
	logic               wrap;
	logic [4:0]         m1w;
	status_t            status;
	logic [YEAR_W-1:0]  yrs;
	logic [MONS_W-1:0]  mos;
	logic [DAYS_W-1:0]  dys;

	logic               out_valid_q;
	status_t            status_q;
	logic [YEAR_W-1:0]  yrs_q;
	logic [MONS_W-1:0]  mos_q;
	logic [DAYS_W-1:0]  dys_q;

	// only an end record needs the result register
	assign take      = rec_valid && (!rec.second || !out_valid_q || m_tready);
	assign rec_ready = !rec_valid || take;

	// date check with gregorian leap years
	always_comb begin
		y_adj  = (rec.year <= YEAR_SHORT_MAX) ? 14'(rec.year + YEAR_OFFSET) : rec.year;
		y_inv  = 14'(y_adj * INV25);
		leap   = (y_adj[1:0] == 2'b00) && ((y_inv > DIV25_MAX) || (y_adj[3:0] == 4'd0));
		mon    = rec.month[3:0];
		mlen   = month_len(mon, leap);
		len_ok = (rec.len_day >= 3'd1) && (rec.len_day <= CAP_SHORT)
			&& (rec.len_month >= 3'd1) && (rec.len_month <= CAP_SHORT)
			&& ((rec.len_year == CAP_SHORT) || (rec.len_year == CAP_YEAR));
		ok     = len_ok && (rec.month >= 7'd1) && (rec.month <= 7'd12)
			&& (rec.day >= 7'd1) && (rec.day <= {2'b00, mlen});
	end

	// difference by borrowing the length of the month before the end month
	always_comb begin
		later  = (start_year_q > y_adj)
			|| ((start_year_q == y_adj) && (start_month_q > mon))
			|| ((start_year_q == y_adj) && (start_month_q == mon)
				&& (start_day_q > rec.day));
		borrow = start_day_q > rec.day;
		m1b    = borrow ? 4'(mon - 4'd1) : mon;
		d1b    = borrow ? 8'({1'b0, rec.day} + {3'd0, month_len(m1b, leap)})
			: {1'b0, rec.day};
		wrap   = start_month_q > m1b;
		m1w    = wrap ? 5'({1'b0, m1b} + {1'b0, MONTHS_PER_YEAR}) : {1'b0, m1b};
		yrs    = '0;
		mos    = '0;
		dys    = '0;
		if (!start_valid_q) begin
			status = STAT_START_BAD;
		end else if (!ok) begin
			status = STAT_END_BAD;
		end else if (later) begin
			status = STAT_ORDER;
		end else begin
			status = STAT_OK;
			dys    = 6'(d1b - {1'b0, start_day_q});
			mos    = 4'(m1w - {1'b0, start_month_q});
			yrs    = 14'(y_adj - start_year_q - {13'd0, wrap});
		end
	end

	// start date store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_valid_q <= 1'b0;
			start_day_q   <= '0;
			start_month_q <= '0;
			start_year_q  <= '0;
		end else if (take && !rec.second) begin
			start_valid_q <= ok;
			start_day_q   <= rec.day;
			start_month_q <= rec.month[3:0];
			start_year_q  <= y_adj;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && rec.second) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && rec.second) begin
			status_q <= status;
			yrs_q    <= yrs;
			mos_q    <= mos;
			dys_q    <= dys;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {dys_q, mos_q, yrs_q};

endmodule
